// File: src/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg: shared constants and types for the quaternion to matrix converter
// Widths of components, products, norm and divider remainder.
// ----------------------------------------------------------------------------
`default_nettype none
package qrm_pkg;
  localparam int COMPONENT_BITS = 16;
  localparam int FRAC_BITS      = COMPONENT_BITS - 2;
  localparam int PROD_BITS      = 2 * COMPONENT_BITS;
  localparam int NORM_BITS      = PROD_BITS + 1;
  localparam int REM_BITS       = NORM_BITS + 1;
  localparam int DIV_STEPS      = FRAC_BITS + 2;
  localparam int LANES          = 9;

  typedef logic signed [COMPONENT_BITS-1:0] comp_t;
  typedef logic        [NORM_BITS-1:0]      norm_t;
  typedef logic        [REM_BITS-1:0]       rem_t;
  typedef logic        [DIV_STEPS-1:0]      quo_t;

  localparam comp_t ONE_VAL = comp_t'(1 << FRAC_BITS);
endpackage
`default_nettype wire

// File: src/qrm_if.sv
// ----------------------------------------------------------------------------
// qrm_in_if / qrm_out_if: valid/ready channels of the converter
// Input carries one quaternion, output one matrix and the zero-norm flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface qrm_in_if;
  logic                 valid;
  logic                 ready;
  qrm_pkg::comp_t       q_w;
  qrm_pkg::comp_t       q_x;
  qrm_pkg::comp_t       q_y;
  qrm_pkg::comp_t       q_z;
  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink   (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qrm_out_if;
  logic                 valid;
  logic                 ready;
  qrm_pkg::comp_t       r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic                 zero_norm;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  zero_norm, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  zero_norm, output ready);
endinterface
`default_nettype wire

// File: src/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix: Q1.14 quaternion to 3x3 rotation matrix
// Pipelined: products, norm and numerators, one restoring divide step per
// stage for all nine elements, then rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in_q  : one quaternion (q_w, q_x, q_y, q_z) per transaction, Q1.14.
//   out_r : nine matrix elements r00..r22 in Q1.14 plus zero_norm.
//   A transaction completes when valid and ready are both high.
// Throughput: one transaction per cycle while out_r.ready is high.
// Depth: 20 register stages (input register, product stage, sum stage, 16
//   divide stages, output stage). The divide chain of one compare-subtract
//   per stage sets the depth.
// Every element is the exact quotient by the squared norm, rounded to
//   nearest (ties away from zero) and saturated to +-1.0. A zero quaternion
//   gives the identity matrix with zero_norm set.
// Reset (rst_n low, synchronous) clears all stage valid bits; data in flight
//   is dropped.
// Stall: when the output holds a result that is not taken, the whole pipeline
//   holds; in_q.ready is low only then.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_rotation_matrix (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qrm_in_if.sink     in_q,
  qrm_out_if.source  out_r
);
  import qrm_pkg::*;

  logic adv;

  // input stage
  logic  in_v_r;
  comp_t w_r, x_r, y_r, z_r;

  // product stage
  logic p_v_r;
  logic signed [PROD_BITS-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r,
                               wx_r, wy_r, wz_r;

  // sum stage
  logic  s_v_r, s_zero_r;
  norm_t s_den_r;
  norm_t s_num_r [LANES];
  logic  s_neg_r [LANES];

  // divide stages
  logic  d_v_r    [DIV_STEPS];
  logic  d_zero_r [DIV_STEPS];
  norm_t d_den_r  [DIV_STEPS];
  rem_t  d_rem_r  [DIV_STEPS][LANES];
  quo_t  d_quo_r  [DIV_STEPS][LANES];
  logic  d_neg_r  [DIV_STEPS][LANES];
  rem_t  d_rem_nxt [DIV_STEPS][LANES];
  quo_t  d_quo_nxt [DIV_STEPS][LANES];

  // output stage
  logic  out_v_r, out_zero_r;
  comp_t out_e_r [LANES];
  comp_t out_e_nxt [LANES];

  logic [PROD_BITS-1:0] a_d [3];
  logic [PROD_BITS-1:0] b_d [3];
  logic signed [PROD_BITS:0] s_o [6];
  norm_t num_nxt [LANES];
  logic  neg_nxt [LANES];
  norm_t den_nxt;

  assign adv        = !out_v_r || out_r.ready;
  assign in_q.ready = adv;

  // hold the quaternion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (adv) begin
      in_v_r <= in_q.valid;
    end
    if (adv) begin
      w_r <= in_q.q_w;
      x_r <= in_q.q_x;
      y_r <= in_q.q_y;
      z_r <= in_q.q_z;
    end
  end

  // form the ten products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= in_v_r;
    end
    if (adv) begin
      ww_r <= w_r * w_r;
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      zz_r <= z_r * z_r;
      xy_r <= x_r * y_r;
      xz_r <= x_r * z_r;
      yz_r <= y_r * z_r;
      wx_r <= w_r * x_r;
      wy_r <= w_r * y_r;
      wz_r <= w_r * z_r;
    end
  end

  // norm, numerator magnitudes and signs
  always_comb begin
    a_d[0] = ww_r + xx_r;  b_d[0] = yy_r + zz_r;
    a_d[1] = ww_r + yy_r;  b_d[1] = xx_r + zz_r;
    a_d[2] = ww_r + zz_r;  b_d[2] = xx_r + yy_r;
    den_nxt = {1'b0, a_d[0]} + {1'b0, b_d[0]};
    s_o[0] = {xy_r[PROD_BITS-1], xy_r} - {wz_r[PROD_BITS-1], wz_r};
    s_o[1] = {xz_r[PROD_BITS-1], xz_r} + {wy_r[PROD_BITS-1], wy_r};
    s_o[2] = {xy_r[PROD_BITS-1], xy_r} + {wz_r[PROD_BITS-1], wz_r};
    s_o[3] = {yz_r[PROD_BITS-1], yz_r} - {wx_r[PROD_BITS-1], wx_r};
    s_o[4] = {xz_r[PROD_BITS-1], xz_r} - {wy_r[PROD_BITS-1], wy_r};
    s_o[5] = {yz_r[PROD_BITS-1], yz_r} + {wx_r[PROD_BITS-1], wx_r};
    for (int k = 0; k < 3; k++) begin
      neg_nxt[4*k] = a_d[k] < b_d[k];
      num_nxt[4*k] = neg_nxt[4*k] ? {1'b0, b_d[k] - a_d[k]}
                                  : {1'b0, a_d[k] - b_d[k]};
    end
    // off-diagonal lanes 1,2,3,5,6,7 take sums 0..5
    for (int j = 0; j < 6; j++) begin
      logic [PROD_BITS:0] mag;
      int lane;
      mag  = s_o[j][PROD_BITS] ? PROD_BITS'(0) - s_o[j] : s_o[j];
      lane = (j < 3) ? j + 1 : j + 2;
      neg_nxt[lane] = s_o[j][PROD_BITS];
      num_nxt[lane] = {mag[PROD_BITS-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (adv) begin
      s_v_r <= p_v_r;
    end
    if (adv) begin
      s_den_r  <= den_nxt;
      s_zero_r <= den_nxt == '0;
      for (int k = 0; k < LANES; k++) begin
        s_num_r[k] <= num_nxt[k];
        s_neg_r[k] <= neg_nxt[k];
      end
    end
  end

  // one restoring divide step per stage and lane
  always_comb begin
    for (int d = 0; d < DIV_STEPS; d++) begin
      for (int k = 0; k < LANES; k++) begin
        rem_t r;
        quo_t q;
        norm_t den;
        if (d == 0) begin
          r   = {1'b0, s_num_r[k]};
          q   = '0;
          den = s_den_r;
        end else begin
          r   = {d_rem_r[d-1][k][REM_BITS-2:0], 1'b0};
          q   = d_quo_r[d-1][k];
          den = d_den_r[d-1];
        end
        if (r >= {1'b0, den}) begin
          d_rem_nxt[d][k] = r - {1'b0, den};
          d_quo_nxt[d][k] = {q[DIV_STEPS-2:0], 1'b1};
        end else begin
          d_rem_nxt[d][k] = r;
          d_quo_nxt[d][k] = {q[DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DIV_STEPS; d++) d_v_r[d] <= 1'b0;
    end else if (adv) begin
      d_v_r[0] <= s_v_r;
      for (int d = 1; d < DIV_STEPS; d++) d_v_r[d] <= d_v_r[d-1];
    end
    if (adv) begin
      d_den_r[0]  <= s_den_r;
      d_zero_r[0] <= s_zero_r;
      for (int d = 1; d < DIV_STEPS; d++) begin
        d_den_r[d]  <= d_den_r[d-1];
        d_zero_r[d] <= d_zero_r[d-1];
      end
      for (int d = 0; d < DIV_STEPS; d++) begin
        for (int k = 0; k < LANES; k++) begin
          d_rem_r[d][k] <= d_rem_nxt[d][k];
          d_quo_r[d][k] <= d_quo_nxt[d][k];
          d_neg_r[d][k] <= (d == 0) ? s_neg_r[k] : d_neg_r[d-1][k];
        end
      end
    end
  end

  // round half away from zero, saturate, apply sign
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic [DIV_STEPS:0]   qp;
      logic [DIV_STEPS-1:0] qr;
      comp_t mag;
      qp = {1'b0, d_quo_r[DIV_STEPS-1][k]} + 1'b1;
      qr = qp[DIV_STEPS:1];
      mag = (qr > DIV_STEPS'(ONE_VAL)) ? ONE_VAL : comp_t'(qr);
      if (d_zero_r[DIV_STEPS-1]) begin
        out_e_nxt[k] = (k % 4 == 0) ? ONE_VAL : '0;
      end else begin
        out_e_nxt[k] = d_neg_r[DIV_STEPS-1][k] ? -mag : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= d_v_r[DIV_STEPS-1];
    end
    if (adv) begin
      out_zero_r <= d_zero_r[DIV_STEPS-1];
      for (int k = 0; k < LANES; k++) out_e_r[k] <= out_e_nxt[k];
    end
  end

  assign out_r.valid     = out_v_r;
  assign out_r.zero_norm = out_zero_r;
  assign out_r.r00 = out_e_r[0];
  assign out_r.r01 = out_e_r[1];
  assign out_r.r02 = out_e_r[2];
  assign out_r.r10 = out_e_r[3];
  assign out_r.r11 = out_e_r[4];
  assign out_r.r12 = out_e_r[5];
  assign out_r.r20 = out_e_r[6];
  assign out_r.r21 = out_e_r[7];
  assign out_r.r22 = out_e_r[8];

  // a zero quaternion gives ones on the diagonal and a zero r01
  a_zero_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_zero_r |-> out_e_r[0] == ONE_VAL && out_e_r[1] == '0 &&
      out_e_r[4] == ONE_VAL && out_e_r[8] == ONE_VAL)
    else $error("zero norm result is not the identity");

  // elements r00 and r01 never exceed one in magnitude
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_e_r[0] <= ONE_VAL && out_e_r[0] >= -ONE_VAL &&
      out_e_r[1] <= ONE_VAL && out_e_r[1] >= -ONE_VAL)
    else $error("matrix element out of range");

  // a held pipeline keeps the sum and last divide stage valid bits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(d_v_r[DIV_STEPS-1]) && $stable(s_v_r))
    else $error("pipeline moved while stalled");

  // input is taken whenever the output is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_q.ready)
    else $error("input refused with empty output");
endmodule
`default_nettype wire
